// ----- src/pps_pkg.sv -----
// Shared types, widths and constants of the preemptive priority scheduler.
package pps_pkg;

   localparam int MAX_TASKS = 16;
   localparam int SLOT_W    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CNT_W     = $clog2(MAX_TASKS + 1);

   localparam int TIME_W    = 16;
   localparam int PRIO_W    = 8;
   localparam int SUM_W     = 20;
   localparam int FCNT_W    = 5;
   localparam int SLOTF_W   = 4;

   localparam logic [TIME_W-1:0] TIME_MAX  = '1;
   localparam logic [FCNT_W-1:0] COUNT_MAX = '1;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_TICK = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_STEP,
      ST_ACCUM,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [TIME_W-1:0] arrival;
      logic [TIME_W-1:0] burst;
      logic [PRIO_W-1:0] prio;
      logic [TIME_W-1:0] remain;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic              rd_en;
      logic [SLOT_W-1:0] rd_addr;
      logic              wr_en;
      logic [SLOT_W-1:0] wr_addr;
      entry_type         wr_data;
   } ram_ctl_type;

endpackage

// ----- src/pps_ifs.sv -----
// Valid/ready channel interfaces for the scheduler's item and result streams.
interface pps_req_if;
   logic                          valid;
   logic                          ready;
   logic                          opcode;
   logic [pps_pkg::SLOTF_W-1:0]   slot;
   logic [pps_pkg::TIME_W-1:0]    arrival_time;
   logic [pps_pkg::TIME_W-1:0]    burst_time;
   logic [pps_pkg::PRIO_W-1:0]    priority_req;

   modport source (output valid, output opcode, output slot, output arrival_time,
                   output burst_time, output priority_req, input ready);
   modport sink   (input valid, input opcode, input slot, input arrival_time,
                   input burst_time, input priority_req, output ready);
endinterface

interface pps_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          ran;
   logic [pps_pkg::SLOTF_W-1:0]   ran_slot;
   logic                          new_slice;
   logic [pps_pkg::TIME_W-1:0]    slice_time;
   logic                          finished;
   logic [pps_pkg::TIME_W-1:0]    completion_time;
   logic [pps_pkg::TIME_W-1:0]    turnaround;
   logic [pps_pkg::TIME_W-1:0]    waiting;
   logic [pps_pkg::SUM_W-1:0]     waiting_sum;
   logic [pps_pkg::SUM_W-1:0]     turnaround_sum;
   logic                          all_done;

   modport source (output valid, output ran, output ran_slot, output new_slice,
                   output slice_time, output finished, output completion_time,
                   output turnaround, output waiting, output waiting_sum,
                   output turnaround_sum, output all_done, input ready);
   modport sink   (input valid, input ran, input ran_slot, input new_slice,
                   input slice_time, input finished, input completion_time,
                   input turnaround, input waiting, input waiting_sum,
                   input turnaround_sum, input all_done, output ready);
endinterface

// ----- src/pps_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module pps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic                             rd_en,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/preemptive_priority_scheduler.sv -----
// Top level of the preemptive priority scheduler: sequencer, scan compare and result register.
//
// Usage. Items arrive on req_ch (valid/ready). A load item (opcode load) writes one task
// slot with arrival time, burst and priority; a tick item advances time by one unit,
// runs the ready unfinished task of lowest priority value (lowest slot on a tie) and
// reports the slice and, on completion, turnaround and waiting times. Every item gives
// exactly one result on rsp_ch. The user writes task_count via csr_wr_en and csr_wr_data
// only while the block is idle (the block does not enforce it); it only drives all_done.
//
// Timing. A load writes its slot and goes straight to the finish state. A tick walks
// the task table one slot per cycle through the single read port of the task RAM and
// one comparator, then steps time and the chosen task, accounts any completion and
// registers its result. The block takes one item at a time.
//
// Reset (synchronous, active high) marks every slot as not runnable, clears time, the
// running sums, the finished count and the slice history. The task RAM itself is not
// cleared. When the receiver stalls, the result waits in the output register and the
// block may still accept the next item; it holds that item's result until the previous
// result has been transferred.
module preemptive_priority_scheduler (
   input  logic                        clock,
   input  logic                        reset,
   pps_req_if.sink                     req_ch,
   pps_rsp_if.source                   rsp_ch,
   input  logic                        csr_wr_en,
   input  logic [pps_pkg::FCNT_W-1:0]  csr_wr_data
);

   // Sequencer state.
   pps_pkg::state_type state_ff, state_in;

   // Scan control: cnt_ff is the slot being issued to the RAM, eidx_ff the slot whose
   // data comes back from the RAM in this cycle.
   logic [pps_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic [pps_pkg::SLOT_W-1:0]  eidx_ff, eidx_in;
   logic                        evld_ff, evld_in;

   // Best candidate found so far, with a copy of its table entry.
   logic                        pick_vld_ff, pick_vld_in;
   logic [pps_pkg::SLOT_W-1:0]  pick_ff, pick_in;
   logic [pps_pkg::PRIO_W-1:0]  best_ff, best_in;
   logic [pps_pkg::TIME_W-1:0]  pk_arr_ff, pk_arr_in;
   logic [pps_pkg::TIME_W-1:0]  pk_burst_ff, pk_burst_in;
   logic [pps_pkg::TIME_W-1:0]  pk_rem_ff, pk_rem_in;

   // Scheduler state.
   logic [pps_pkg::MAX_TASKS-1:0] run_ff, run_in;
   logic [pps_pkg::TIME_W-1:0]    now_ff, now_in;
   logic [pps_pkg::FCNT_W-1:0]    fin_cnt_ff, fin_cnt_in;
   logic [pps_pkg::SLOT_W-1:0]    last_slot_ff, last_slot_in;
   logic                          last_vld_ff, last_vld_in;
   logic [pps_pkg::SUM_W-1:0]     wait_total_ff, wait_total_in;
   logic [pps_pkg::SUM_W-1:0]     turn_total_ff, turn_total_in;
   logic [pps_pkg::FCNT_W-1:0]    task_count_ff, task_count_in;

   // Per-item staging between the step, accumulate and finish cycles.
   logic                          tick_ff, tick_in;
   logic                          newsl_ff, newsl_in;
   logic                          fin_ff, fin_in;
   logic [pps_pkg::TIME_W-1:0]    slice_ff, slice_in;
   logic [pps_pkg::TIME_W-1:0]    tat_ff, tat_in;
   logic [pps_pkg::TIME_W-1:0]    wt_ff, wt_in;

   // Result register.
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          o_ran_ff, o_ran_in;
   logic [pps_pkg::SLOTF_W-1:0]   o_slot_ff, o_slot_in;
   logic                          o_newsl_ff, o_newsl_in;
   logic [pps_pkg::TIME_W-1:0]    o_slice_ff, o_slice_in;
   logic                          o_fin_ff, o_fin_in;
   logic [pps_pkg::TIME_W-1:0]    o_comp_ff, o_comp_in;
   logic [pps_pkg::TIME_W-1:0]    o_tat_ff, o_tat_in;
   logic [pps_pkg::TIME_W-1:0]    o_wt_ff, o_wt_in;
   logic [pps_pkg::SUM_W-1:0]     o_wsum_ff, o_wsum_in;
   logic [pps_pkg::SUM_W-1:0]     o_tsum_ff, o_tsum_in;
   logic                          o_done_ff, o_done_in;

   pps_pkg::ram_ctl_type        ram_ctl;
   pps_pkg::entry_type          rd_entry;
   logic [pps_pkg::ENTRY_W-1:0] rd_raw;

   logic                        req_xfer;
   logic                        load_ok;
   logic [pps_pkg::SLOT_W-1:0]  ld_idx;
   logic                        scan_busy;
   logic                        cand;
   logic                        out_free;
   logic [pps_pkg::TIME_W-1:0]  rem_dec;
   logic [pps_pkg::TIME_W-1:0]  now_inc;
   logic [pps_pkg::SUM_W:0]     wsum_raw;
   logic [pps_pkg::SUM_W:0]     tsum_raw;

   assign req_ch.ready = (state_ff == pps_pkg::ST_IDLE);
   assign req_xfer     = req_ch.valid && req_ch.ready;
   assign ld_idx       = pps_pkg::SLOT_W'(req_ch.slot);
   assign load_ok      = (32'(req_ch.slot) < pps_pkg::MAX_TASKS);
   assign scan_busy    = (cnt_ff < pps_pkg::CNT_W'(pps_pkg::MAX_TASKS));
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign rd_entry     = pps_pkg::entry_type'(rd_raw);

   // The one comparator pair of the scan: is the returning slot runnable, already
   // arrived, and strictly better than the best so far?
   assign cand = evld_ff && run_ff[eidx_ff] && (rd_entry.arrival <= now_ff) &&
                 (!pick_vld_ff || (rd_entry.prio < best_ff));

   assign rem_dec = pk_rem_ff - 1'b1;
   assign now_inc = (now_ff != pps_pkg::TIME_MAX) ? now_ff + 1'b1 : now_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pps_pkg::ST_IDLE: begin
            if (req_xfer) begin
               state_in = (req_ch.opcode == pps_pkg::OP_TICK) ? pps_pkg::ST_SCAN
                                                              : pps_pkg::ST_FINISH;
            end
         end
         pps_pkg::ST_SCAN: begin
            if (!scan_busy) begin
               state_in = pps_pkg::ST_STEP;
            end
         end
         pps_pkg::ST_STEP:  state_in = pps_pkg::ST_ACCUM;
         pps_pkg::ST_ACCUM: state_in = pps_pkg::ST_FINISH;
         pps_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = pps_pkg::ST_IDLE;
            end
         end
         default: state_in = pps_pkg::ST_IDLE;
      endcase
   end

   // RAM control strobes of the sequencer.
   always_comb begin
      ram_ctl = '0;
      case (state_ff)
         pps_pkg::ST_IDLE: begin
            // A load writes its slot right at the input transfer; the remaining
            // time starts at the burst.
            ram_ctl.wr_en   = req_xfer && (req_ch.opcode == pps_pkg::OP_LOAD) && load_ok;
            ram_ctl.wr_addr = ld_idx;
            ram_ctl.wr_data = '{arrival: req_ch.arrival_time, burst: req_ch.burst_time,
                                prio: req_ch.priority_req, remain: req_ch.burst_time};
         end
         pps_pkg::ST_SCAN: begin
            ram_ctl.rd_en   = scan_busy;
            ram_ctl.rd_addr = cnt_ff[pps_pkg::SLOT_W-1:0];
         end
         pps_pkg::ST_STEP: begin
            // Write back the chosen task with one unit less to run.
            ram_ctl.wr_en   = pick_vld_ff;
            ram_ctl.wr_addr = pick_ff;
            ram_ctl.wr_data = '{arrival: pk_arr_ff, burst: pk_burst_ff,
                                prio: best_ff, remain: rem_dec};
         end
         default: ram_ctl = '0;
      endcase
   end

   // Datapath next values.
   always_comb begin
      cnt_in        = cnt_ff;
      eidx_in       = eidx_ff;
      evld_in       = 1'b0;
      pick_vld_in   = pick_vld_ff;
      pick_in       = pick_ff;
      best_in       = best_ff;
      pk_arr_in     = pk_arr_ff;
      pk_burst_in   = pk_burst_ff;
      pk_rem_in     = pk_rem_ff;
      run_in        = run_ff;
      now_in        = now_ff;
      fin_cnt_in    = fin_cnt_ff;
      last_slot_in  = last_slot_ff;
      last_vld_in   = last_vld_ff;
      wait_total_in = wait_total_ff;
      turn_total_in = turn_total_ff;
      task_count_in = csr_wr_en ? csr_wr_data : task_count_ff;
      tick_in       = tick_ff;
      newsl_in      = newsl_ff;
      fin_in        = fin_ff;
      slice_in      = slice_ff;
      tat_in        = tat_ff;
      wt_in         = wt_ff;
      wsum_raw      = {1'b0, wait_total_ff} + pps_pkg::SUM_W'(wt_ff);
      tsum_raw      = {1'b0, turn_total_ff} + pps_pkg::SUM_W'(tat_ff);

      case (state_ff)
         pps_pkg::ST_IDLE: begin
            if (req_xfer) begin
               tick_in     = (req_ch.opcode == pps_pkg::OP_TICK);
               cnt_in      = '0;
               pick_vld_in = 1'b0;
               if ((req_ch.opcode == pps_pkg::OP_LOAD) && load_ok) begin
                  run_in[ld_idx] = (req_ch.burst_time != '0);
               end
            end
         end
         pps_pkg::ST_SCAN: begin
            if (scan_busy) begin
               cnt_in  = cnt_ff + 1'b1;
               eidx_in = cnt_ff[pps_pkg::SLOT_W-1:0];
               evld_in = 1'b1;
            end
            if (cand) begin
               pick_vld_in = 1'b1;
               pick_in     = eidx_ff;
               best_in     = rd_entry.prio;
               pk_arr_in   = rd_entry.arrival;
               pk_burst_in = rd_entry.burst;
               pk_rem_in   = rd_entry.remain;
            end
         end
         pps_pkg::ST_STEP: begin
            now_in   = now_inc;
            slice_in = now_ff;
            newsl_in = !last_vld_ff || (last_slot_ff != pick_ff);
            fin_in   = pick_vld_ff && (rem_dec == '0);
            tat_in   = now_inc - pk_arr_ff;
            if (pick_vld_ff) begin
               last_slot_in = pick_ff;
               last_vld_in  = 1'b1;
               if (rem_dec == '0) begin
                  run_in[pick_ff] = 1'b0;
               end
            end
         end
         pps_pkg::ST_ACCUM: begin
            // Saturated time can make turnaround shorter than the burst.
            wt_in = (tat_ff >= pk_burst_ff) ? tat_ff - pk_burst_ff : '0;
            if (fin_ff) begin
               wsum_raw      = {1'b0, wait_total_ff} + pps_pkg::SUM_W'(wt_in);
               wait_total_in = wsum_raw[pps_pkg::SUM_W] ? '1
                                                        : wsum_raw[pps_pkg::SUM_W-1:0];
               turn_total_in = tsum_raw[pps_pkg::SUM_W] ? '1
                                                        : tsum_raw[pps_pkg::SUM_W-1:0];
               if (fin_cnt_ff != pps_pkg::COUNT_MAX) begin
                  fin_cnt_in = fin_cnt_ff + 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Result register: loaded in the finish state once the previous result is gone.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      o_ran_in     = o_ran_ff;
      o_slot_in    = o_slot_ff;
      o_newsl_in   = o_newsl_ff;
      o_slice_in   = o_slice_ff;
      o_fin_in     = o_fin_ff;
      o_comp_in    = o_comp_ff;
      o_tat_in     = o_tat_ff;
      o_wt_in      = o_wt_ff;
      o_wsum_in    = o_wsum_ff;
      o_tsum_in    = o_tsum_ff;
      o_done_in    = o_done_ff;
      if ((state_ff == pps_pkg::ST_FINISH) && out_free) begin
         rsp_valid_in = 1'b1;
         o_ran_in     = tick_ff && pick_vld_ff;
         o_slot_in    = o_ran_in ? pps_pkg::SLOTF_W'(pick_ff) : '0;
         o_newsl_in   = o_ran_in && newsl_ff;
         o_slice_in   = o_ran_in ? slice_ff : '0;
         o_fin_in     = o_ran_in && fin_ff;
         o_comp_in    = o_fin_in ? now_ff : '0;
         o_tat_in     = o_fin_in ? tat_ff : '0;
         o_wt_in      = o_fin_in ? wt_ff : '0;
         o_wsum_in    = wait_total_ff;
         o_tsum_in    = turn_total_ff;
         o_done_in    = (fin_cnt_ff == task_count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= pps_pkg::ST_IDLE;
         cnt_ff        <= '0;
         evld_ff       <= 1'b0;
         pick_vld_ff   <= 1'b0;
         run_ff        <= '0;
         now_ff        <= '0;
         fin_cnt_ff    <= '0;
         last_slot_ff  <= '0;
         last_vld_ff   <= 1'b0;
         wait_total_ff <= '0;
         turn_total_ff <= '0;
         task_count_ff <= '0;
         tick_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         evld_ff       <= evld_in;
         pick_vld_ff   <= pick_vld_in;
         run_ff        <= run_in;
         now_ff        <= now_in;
         fin_cnt_ff    <= fin_cnt_in;
         last_slot_ff  <= last_slot_in;
         last_vld_ff   <= last_vld_in;
         wait_total_ff <= wait_total_in;
         turn_total_ff <= turn_total_in;
         task_count_ff <= task_count_in;
         tick_ff       <= tick_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      eidx_ff     <= eidx_in;
      pick_ff     <= pick_in;
      best_ff     <= best_in;
      pk_arr_ff   <= pk_arr_in;
      pk_burst_ff <= pk_burst_in;
      pk_rem_ff   <= pk_rem_in;
      newsl_ff    <= newsl_in;
      fin_ff      <= fin_in;
      slice_ff    <= slice_in;
      tat_ff      <= tat_in;
      wt_ff       <= wt_in;
      o_ran_ff    <= o_ran_in;
      o_slot_ff   <= o_slot_in;
      o_newsl_ff  <= o_newsl_in;
      o_slice_ff  <= o_slice_in;
      o_fin_ff    <= o_fin_in;
      o_comp_ff   <= o_comp_in;
      o_tat_ff    <= o_tat_in;
      o_wt_ff     <= o_wt_in;
      o_wsum_ff   <= o_wsum_in;
      o_tsum_ff   <= o_tsum_in;
      o_done_ff   <= o_done_in;
   end

   pps_ram #(
      .WIDTH (pps_pkg::ENTRY_W),
      .DEPTH (pps_pkg::MAX_TASKS)
   ) u_task_ram (
      .clock   (clock),
      .wr_en   (ram_ctl.wr_en),
      .wr_addr (ram_ctl.wr_addr),
      .wr_data (ram_ctl.wr_data),
      .rd_en   (ram_ctl.rd_en),
      .rd_addr (ram_ctl.rd_addr),
      .rd_data (rd_raw)
   );

   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.ran             = o_ran_ff;
   assign rsp_ch.ran_slot        = o_slot_ff;
   assign rsp_ch.new_slice       = o_newsl_ff;
   assign rsp_ch.slice_time      = o_slice_ff;
   assign rsp_ch.finished        = o_fin_ff;
   assign rsp_ch.completion_time = o_comp_ff;
   assign rsp_ch.turnaround      = o_tat_ff;
   assign rsp_ch.waiting         = o_wt_ff;
   assign rsp_ch.waiting_sum     = o_wsum_ff;
   assign rsp_ch.turnaround_sum  = o_tsum_ff;
   assign rsp_ch.all_done        = o_done_ff;

   // A completion is always reported on a tick in which a task ran.
   a_fin_needs_run: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.finished |-> rsp_ch.ran)
      else $error("completion reported without a running task");

   // Completion time is the slice start plus one, unless time has saturated.
   a_comp_time: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.finished && (rsp_ch.slice_time != pps_pkg::TIME_MAX) |->
      (rsp_ch.completion_time == rsp_ch.slice_time + 1'b1))
      else $error("completion time does not follow the slice start");

   // Waiting never exceeds turnaround.
   a_wait_le_tat: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.finished |-> (rsp_ch.waiting <= rsp_ch.turnaround))
      else $error("waiting time exceeds turnaround time");

   // The running sums only grow.
   a_sums_grow: assert property (@(posedge clock) disable iff (reset)
      (wait_total_ff >= $past(wait_total_ff)) && (turn_total_ff >= $past(turn_total_ff)))
      else $error("running sum decreased");

endmodule

// ----- bench/tb_top.sv -----
// Self-checking testbench of the preemptive priority scheduler: load and tick stimulus, scoreboard.
`timescale 1ns / 1ps

module tb_top;

   // Run-length guard. It ends a hung run. With the random idling on both sides and the
   // two long receiver hold-offs, a correct run of about 1400 items stays far below it.
   localparam int LIMIT_CYCLES = 400_000;
   localparam int HOLD_CYCLES  = 300;
   localparam int TICK_CYCLES  = pps_pkg::MAX_TASKS + 5;
   localparam int RANDOM_ITEMS = 1240;
   localparam int LAST_ITEMS   = 140;
   localparam int MAX_PRINTED  = 100;

   // One input item as it travels on the request channel.
   typedef struct packed {
      logic                        opcode;
      logic [pps_pkg::SLOTF_W-1:0] slot;
      logic [pps_pkg::TIME_W-1:0]  arrival;
      logic [pps_pkg::TIME_W-1:0]  burst;
      logic [pps_pkg::PRIO_W-1:0]  prio;
   } sched_item_type;

   // One result as it travels on the response channel.
   typedef struct packed {
      logic                        ran;
      logic [pps_pkg::SLOTF_W-1:0] ran_slot;
      logic                        new_slice;
      logic [pps_pkg::TIME_W-1:0]  slice_time;
      logic                        finished;
      logic [pps_pkg::TIME_W-1:0]  completion_time;
      logic [pps_pkg::TIME_W-1:0]  turnaround;
      logic [pps_pkg::TIME_W-1:0]  waiting;
      logic [pps_pkg::SUM_W-1:0]   waiting_sum;
      logic [pps_pkg::SUM_W-1:0]   turnaround_sum;
      logic                        all_done;
   } sched_result_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [pps_pkg::FCNT_W-1:0] csr_wr_data;

   pps_req_if req_if ();
   pps_rsp_if rsp_if ();

   preemptive_priority_scheduler dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_if),
      .rsp_ch      (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Items waiting to be offered, and the results that the accepted items must produce,
   // oldest first.
   sched_item_type   pending_items[$];
   sched_result_type outcome_q[$];

   int unsigned queued_count;
   int unsigned accepted_count;
   int unsigned mismatches;
   int unsigned cycle_count;

   // Simulated time as it will stand once every queued tick has been processed. The
   // stimulus uses it to place arrivals close to the moment the tasks are loaded.
   logic [pps_pkg::TIME_W-1:0] gen_now;

   // Idle control. quiet switches the random idling off on both sides; a long receiver
   // hold-off is requested by bumping holds_asked, and the receiver counts it out itself.
   logic        quiet;
   int unsigned holds_asked;

   // Predicted scheduler state, a private copy kept beside the block.
   logic [pps_pkg::TIME_W-1:0]  slot_arrival [pps_pkg::MAX_TASKS];
   logic [pps_pkg::TIME_W-1:0]  slot_burst   [pps_pkg::MAX_TASKS];
   logic [pps_pkg::PRIO_W-1:0]  slot_prio    [pps_pkg::MAX_TASKS];
   logic [pps_pkg::TIME_W-1:0]  slot_remain  [pps_pkg::MAX_TASKS];
   logic [pps_pkg::TIME_W-1:0]  sched_now;
   logic [pps_pkg::FCNT_W-1:0]  done_count;
   logic [pps_pkg::SLOTF_W-1:0] prev_slot;
   logic                        prev_slot_valid;
   logic [pps_pkg::SUM_W-1:0]   wait_acc;
   logic [pps_pkg::SUM_W-1:0]   turn_acc;
   logic [pps_pkg::FCNT_W-1:0]  tasks_in_use;

   // Applies one accepted item to the predicted state and returns the result it must cause.
   // A load only rewrites its slot. A tick picks the ready task of lowest priority value,
   // the first slot found winning a tie, runs it for one unit and, when its remaining time
   // runs out, accounts turnaround and waiting. Time, the sums and the finished count all
   // saturate instead of wrapping.
   function automatic sched_result_type scheduler_outcome(sched_item_type item);
      sched_result_type           res;
      int                         pick;
      int                         i;
      logic [pps_pkg::PRIO_W-1:0] best;
      logic [pps_pkg::TIME_W-1:0] tat;
      logic [pps_pkg::TIME_W-1:0] wt;
      logic [pps_pkg::SUM_W:0]    wide_sum;
      res  = '0;
      pick = -1;
      best = '0;
      if (item.opcode == pps_pkg::OP_LOAD) begin
         slot_arrival[item.slot] = item.arrival;
         slot_burst[item.slot]   = item.burst;
         slot_prio[item.slot]    = item.prio;
         slot_remain[item.slot]  = item.burst;
      end else begin
         for (i = 0; i < pps_pkg::MAX_TASKS; i++) begin
            if (slot_remain[i] != 0 && slot_arrival[i] <= sched_now &&
                (pick < 0 || slot_prio[i] < best)) begin
               best = slot_prio[i];
               pick = i;
            end
         end
         if (pick >= 0) begin
            res.ran        = 1'b1;
            res.ran_slot   = pick[pps_pkg::SLOTF_W-1:0];
            res.new_slice  = !prev_slot_valid || prev_slot != pick[pps_pkg::SLOTF_W-1:0];
            res.slice_time = sched_now;
            prev_slot       = pick[pps_pkg::SLOTF_W-1:0];
            prev_slot_valid = 1'b1;
            slot_remain[pick] = slot_remain[pick] - 1'b1;
            if (sched_now != pps_pkg::TIME_MAX) begin
               sched_now = sched_now + 1'b1;
            end
            if (slot_remain[pick] == 0) begin
               // The task was ready, so its arrival never lies after the current time.
               tat = sched_now - slot_arrival[pick];
               // Once time has saturated the turnaround can fall short of the burst; the
               // waiting time is then held at zero.
               wt  = (tat >= slot_burst[pick]) ? tat - slot_burst[pick] : '0;
               res.finished        = 1'b1;
               res.completion_time = sched_now;
               res.turnaround      = tat;
               res.waiting         = wt;
               wide_sum = {1'b0, wait_acc} + (pps_pkg::SUM_W + 1)'(wt);
               wait_acc = wide_sum[pps_pkg::SUM_W] ? '1 : wide_sum[pps_pkg::SUM_W-1:0];
               wide_sum = {1'b0, turn_acc} + (pps_pkg::SUM_W + 1)'(tat);
               turn_acc = wide_sum[pps_pkg::SUM_W] ? '1 : wide_sum[pps_pkg::SUM_W-1:0];
               if (done_count != pps_pkg::COUNT_MAX) begin
                  done_count = done_count + 1'b1;
               end
            end
         end else if (sched_now != pps_pkg::TIME_MAX) begin
            // An idle tick moves time on but leaves the slice history alone.
            sched_now = sched_now + 1'b1;
         end
      end
      res.waiting_sum    = wait_acc;
      res.turnaround_sum = turn_acc;
      res.all_done       = (done_count == tasks_in_use);
      return res;
   endfunction

   // Every mismatch goes through here. Past a fixed number of lines the failures are only
   // counted, so that a badly broken block cannot flood the log.
   task automatic report_mismatch(string msg);
      if (mismatches < MAX_PRINTED) begin
         $display("ERROR at %0t ns: %s", $time, msg);
      end
      mismatches++;
   endtask

   // Clock and reset.
   initial clock = 1'b0;
   always #4 clock = ~clock;

   // Every input of the block holds a known value from time zero on.
   initial begin
      reset        = 1'b1;
      csr_wr_en    = 1'b0;
      csr_wr_data  = '0;
      req_if.valid = 1'b0;
      req_if.opcode       = pps_pkg::OP_LOAD;
      req_if.slot         = '0;
      req_if.arrival_time = '0;
      req_if.burst_time   = '0;
      req_if.priority_req = '0;
      rsp_if.ready = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("FAIL");
         $finish;
      end
   end

   // Driver. At every edge it first retires the item that was just transferred, which is
   // where the prediction is made, and then decides what to offer next: nothing during an
   // idle burst, otherwise the next pending item. valid gets exactly one nonblocking
   // assignment per edge, so an item offered back to back keeps valid high throughout.
   sched_item_type cur_item;
   int unsigned    send_gap;

   always @(posedge clock) begin : drive_items
      logic next_valid;
      if (reset) begin
         send_gap = 0;
         req_if.valid <= 1'b0;
      end else begin
         next_valid = req_if.valid;
         if (req_if.valid && req_if.ready) begin
            outcome_q.push_back(scheduler_outcome(cur_item));
            accepted_count++;
            next_valid = 1'b0;
         end
         if (!next_valid && pending_items.size() > 0) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
               // This cycle stays idle, and send_gap more idle ones follow it.
               send_gap = $urandom_range(0, 3);
            end else begin
               cur_item = pending_items.pop_front();
               req_if.opcode       <= cur_item.opcode;
               req_if.slot         <= cur_item.slot;
               req_if.arrival_time <= cur_item.arrival;
               req_if.burst_time   <= cur_item.burst;
               req_if.priority_req <= cur_item.prio;
               next_valid = 1'b1;
            end
         end
         req_if.valid <= next_valid;
      end
   end

   // Receiver. Random stalls, and on request one long hold-off during which the sender
   // keeps offering, so that the result register fills and the block stops taking items.
   int unsigned holds_started;
   int unsigned hold_left;
   int unsigned stall_left;

   always @(posedge clock) begin
      if (reset) begin
         hold_left  = 0;
         stall_left = 0;
         rsp_if.ready <= 1'b0;
      end else begin
         if (holds_started != holds_asked) begin
            holds_started++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 3);
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // Monitor. Each result transfer is compared field by field with the oldest prediction.
   always @(posedge clock) begin : watch_results
      sched_result_type got;
      sched_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.ran             = rsp_if.ran;
         got.ran_slot        = rsp_if.ran_slot;
         got.new_slice       = rsp_if.new_slice;
         got.slice_time      = rsp_if.slice_time;
         got.finished        = rsp_if.finished;
         got.completion_time = rsp_if.completion_time;
         got.turnaround      = rsp_if.turnaround;
         got.waiting         = rsp_if.waiting;
         got.waiting_sum     = rsp_if.waiting_sum;
         got.turnaround_sum  = rsp_if.turnaround_sum;
         got.all_done        = rsp_if.all_done;
         if (outcome_q.size() == 0) begin
            report_mismatch("result transfer with no item outstanding");
         end else begin
            want = outcome_q.pop_front();
            if (got.ran !== want.ran)
               report_mismatch($sformatf("ran %0h, predicted %0h", got.ran, want.ran));
            if (got.ran_slot !== want.ran_slot)
               report_mismatch($sformatf("ran_slot %0h, predicted %0h",
                                         got.ran_slot, want.ran_slot));
            if (got.new_slice !== want.new_slice)
               report_mismatch($sformatf("new_slice %0h, predicted %0h",
                                         got.new_slice, want.new_slice));
            if (got.slice_time !== want.slice_time)
               report_mismatch($sformatf("slice_time %0h, predicted %0h",
                                         got.slice_time, want.slice_time));
            if (got.finished !== want.finished)
               report_mismatch($sformatf("finished %0h, predicted %0h",
                                         got.finished, want.finished));
            if (got.completion_time !== want.completion_time)
               report_mismatch($sformatf("completion_time %0h, predicted %0h",
                                         got.completion_time, want.completion_time));
            if (got.turnaround !== want.turnaround)
               report_mismatch($sformatf("turnaround %0h, predicted %0h",
                                         got.turnaround, want.turnaround));
            if (got.waiting !== want.waiting)
               report_mismatch($sformatf("waiting %0h, predicted %0h",
                                         got.waiting, want.waiting));
            if (got.waiting_sum !== want.waiting_sum)
               report_mismatch($sformatf("waiting_sum %0h, predicted %0h",
                                         got.waiting_sum, want.waiting_sum));
            if (got.turnaround_sum !== want.turnaround_sum)
               report_mismatch($sformatf("turnaround_sum %0h, predicted %0h",
                                         got.turnaround_sum, want.turnaround_sum));
            if (got.all_done !== want.all_done)
               report_mismatch($sformatf("all_done %0h, predicted %0h",
                                         got.all_done, want.all_done));
         end
      end
   end

   // Stimulus helpers. They only append to the pending queue; gen_now follows the time the
   // queued ticks will reach, saturating as the block does.
   task automatic queue_load(logic [pps_pkg::SLOTF_W-1:0] slot,
                             logic [pps_pkg::TIME_W-1:0] arrival,
                             logic [pps_pkg::TIME_W-1:0] burst,
                             logic [pps_pkg::PRIO_W-1:0] prio);
      sched_item_type item;
      item.opcode  = pps_pkg::OP_LOAD;
      item.slot    = slot;
      item.arrival = arrival;
      item.burst   = burst;
      item.prio    = prio;
      pending_items.push_back(item);
      queued_count++;
   endtask

   task automatic queue_ticks(int unsigned count);
      sched_item_type item;
      item = '0;
      item.opcode = pps_pkg::OP_TICK;
      repeat (count) begin
         pending_items.push_back(item);
         queued_count++;
         if (gen_now != pps_pkg::TIME_MAX) begin
            gen_now = gen_now + 1'b1;
         end
      end
   endtask

   // A well-formed round: a few tasks that arrive soon, then roughly enough ticks to run
   // them. Narrow priority ranges make ties common; short tick runs leave work behind, so
   // that later rounds preempt it.
   task automatic queue_round();
      int unsigned n;
      int unsigned total;
      int unsigned b;
      n     = $urandom_range(1, 5);
      total = 0;
      repeat (n) begin
         b = $urandom_range(1, 8);
         queue_load(pps_pkg::SLOTF_W'($urandom_range(0, pps_pkg::MAX_TASKS - 1)),
                    gen_now + pps_pkg::TIME_W'($urandom_range(0, 6)),
                    pps_pkg::TIME_W'(b),
                    pps_pkg::PRIO_W'($urandom_range(0, 1) ? $urandom_range(0, 3)
                                                           : $urandom_range(0, 255)));
         total += b;
      end
      queue_ticks($urandom_range(total / 2, total + 4));
   endtask

   // Noise: a task parked far in the future with a burst of any size, or a few stray ticks.
   task automatic queue_noise();
      if ($urandom_range(0, 1) == 0) begin
         queue_load(pps_pkg::SLOTF_W'($urandom_range(0, pps_pkg::MAX_TASKS - 1)),
                    {1'b1, 15'($urandom_range(0, 32767))},
                    pps_pkg::TIME_W'($urandom_range(1, 65535)),
                    pps_pkg::PRIO_W'($urandom_range(0, 255)));
      end else begin
         queue_ticks($urandom_range(1, 3));
      end
   endtask

   task automatic queue_random(int unsigned count);
      int unsigned stop_at;
      stop_at = queued_count + count;
      while (queued_count < stop_at) begin
         if ($urandom_range(0, 99) < 85) begin
            queue_round();
         end else begin
            queue_noise();
         end
      end
   endtask

   // Waits on the falling edge, away from every driving edge, until all queued items have
   // been transferred and every predicted result has come back.
   task automatic wait_until_idle();
      while (accepted_count != queued_count || outcome_q.size() != 0) begin
         @(negedge clock);
      end
      repeat (4) @(negedge clock);
   endtask

   // The register is only written with the block idle; the predicted copy changes with it.
   task automatic write_task_count(logic [pps_pkg::FCNT_W-1:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      tasks_in_use = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      int unsigned s;
      queued_count    = 0;
      accepted_count  = 0;
      mismatches      = 0;
      cycle_count     = 0;
      holds_asked     = 0;
      holds_started   = 0;
      quiet           = 1'b0;
      gen_now         = '0;
      sched_now       = '0;
      done_count      = '0;
      prev_slot       = '0;
      prev_slot_valid = 1'b0;
      wait_acc        = '0;
      turn_acc        = '0;
      tasks_in_use    = '0;
      for (s = 0; s < pps_pkg::MAX_TASKS; s++) begin
         slot_remain[s] = '0;
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part. First, with no slot in use, an idle tick on an empty table, then
      // three tasks: the lowest and the highest priority value, in the first and last slot.
      write_task_count(5'd0);
      queue_ticks(1);
      queue_load(4'd0, 16'd0, 16'd2, 8'd255);
      queue_load(4'd15, 16'd0, 16'd1, 8'd0);
      queue_load(4'd7, 16'd3, 16'd3, 8'd0);
      wait_until_idle();

      write_task_count(5'd2);
      // Slot 15 runs and finishes, slot 0 starts, and slot 7 preempts it when it arrives.
      queue_ticks(3);
      // A tie on priority goes to the lower slot, which preempts the running one.
      queue_load(4'd3, 16'd0, 16'd2, 8'd0);
      queue_ticks(2);
      // Reload of the preempted slot 7, and a task with zero burst that must never run.
      queue_load(4'd7, 16'd0, 16'd1, 8'd10);
      queue_load(4'd9, 16'd0, 16'd0, 8'd0);
      queue_ticks(3);
      // A finished slot runs again after a reload; across the idle tick above the last
      // slice stays with slot 0, so no new slice is reported.
      queue_load(4'd0, 16'd0, 16'd1, 8'd128);
      queue_ticks(2);
      wait_until_idle();

      // Random part, in two halves at different register settings, each opening with a
      // long receiver hold-off.
      write_task_count(5'd16);
      holds_asked++;
      queue_random(RANDOM_ITEMS / 2);
      wait_until_idle();

      write_task_count(5'd7);
      holds_asked++;
      queue_random(RANDOM_ITEMS - RANDOM_ITEMS / 2);
      wait_until_idle();

      // Last part, without idling on either side: items follow as fast as the block takes
      // them and every result is taken at once.
      write_task_count(5'd0);
      quiet = 1'b1;
      queue_random(LAST_ITEMS);
      wait_until_idle();

      repeat (2 * TICK_CYCLES) @(negedge clock);
      if (outcome_q.size() != 0) begin
         report_mismatch($sformatf("%0d predicted results never arrived", outcome_q.size()));
      end
      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
